### design/taa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package taa_pkg;

    localparam int COORD_W = 32;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 66;
    localparam int LEN_W   = 33;
    localparam int FAC_W   = 35;
    localparam int MUL_W   = 69;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int RAD_W   = 128;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int AREA_W  = 48;
    localparam int SUM_W   = 63;

    localparam logic [AREA_W-1:0] AREA_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQ_GO   = 4'd1;
    localparam logic [3:0] S_SQ_WAIT = 4'd2;
    localparam logic [3:0] S_RT_GO   = 4'd3;
    localparam logic [3:0] S_RT_WAIT = 4'd4;
    localparam logic [3:0] S_FAC     = 4'd5;
    localparam logic [3:0] S_M1_GO   = 4'd6;
    localparam logic [3:0] S_M1_WAIT = 4'd7;
    localparam logic [3:0] S_M2_GO   = 4'd8;
    localparam logic [3:0] S_M2_WAIT = 4'd9;
    localparam logic [3:0] S_M3_GO   = 4'd10;
    localparam logic [3:0] S_M3_WAIT = 4'd11;
    localparam logic [3:0] S_AR_GO   = 4'd12;
    localparam logic [3:0] S_AR_WAIT = 4'd13;
    localparam logic [3:0] S_SUM     = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic                      final_face;
    } t_tri;

    typedef struct packed {
        logic [AREA_W-1:0] face_area;
        logic [SUM_W-1:0]  area_sum;
        logic              mesh_done;
    } t_res;

endpackage

`default_nettype wire

### design/taa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface taa_tri_if import taa_pkg::*; ();
    logic valid;
    logic ready;
    t_tri data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface taa_res_if import taa_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/taa_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module taa_mul import taa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_p
);
    localparam int CNT_W = $clog2(MUL_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

    logic [PROD_W-1:0] r_acc;
    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [MUL_W:0]    w_sum;

    assign w_sum = {1'b0, r_acc[PROD_W-1:MUL_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[MUL_W-1:1]};
            r_b   <= {1'b0, r_b[MUL_W-1:1]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

`default_nettype wire

### design/taa_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring integer square root, one root bit per cycle
module taa_sqrt import taa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_x,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);
    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic [RAD_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W+1:0]  w_rs;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;

    assign w_rs    = {r_rem, r_x[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rs >= w_trial);
    assign w_diff  = w_rs - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rs[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

### design/triangle_area_accumulator.sv
// Each triangle runs through the bit-serial multiplier (12 products) and the
// bit-serial square root (4 roots); a degenerate triangle skips the Heron
// products and the area root, so its result comes sooner.
// A new triangle is taken only once the last one is finished; a finished result waits
// in the output register while the next triangle is taken.
// Reset (synchronous, active low) clears the running total and all control state.
`timescale 1ns / 1ps
`default_nettype none

module triangle_area_accumulator import taa_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    taa_tri_if.sink    i_tri,
    taa_res_if.source  o_res
);
    localparam int SH = 2 * FRAC_BITS + 4;

    logic [3:0]  r_state, n_state;
    logic signed [COORD_W-1:0] r_vtx [3][3];
    logic        r_final;
    logic [1:0]  r_edge;
    logic [1:0]  r_axis;
    logic [SQ_W-1:0]  r_sq;
    logic [LEN_W-1:0] r_len [3];
    logic [FAC_W-1:0] r_f [4];
    logic [MUL_W-1:0] r_x;
    logic [MUL_W-1:0] r_y;
    logic [PROD_W-1:0] r_p;
    logic [AREA_W-1:0] r_area;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_total;
    logic        r_out_valid;
    t_res        r_res;

    logic [1:0]  w_qi;
    logic signed [COORD_W-1:0] w_p, w_q;
    logic signed [COORD_W:0]   w_d;
    logic [MAG_W-1:0] w_m;
    logic        w_acc_in;
    logic        w_out_free;
    logic        w_mul_start, w_mul_done;
    logic [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic [PROD_W-1:0] w_mul_p;
    logic        w_sq_start, w_sq_done;
    logic [RAD_W-1:0]  w_rad;
    logic [ROOT_W-1:0] w_root;
    logic [PROD_W-1:0] w_psh;
    logic [FAC_W:0]    w_f0, w_f1, w_f2, w_f3;
    logic        w_degen;
    logic [SUM_W:0]    w_sum;

    assign w_acc_in   = i_tri.valid && i_tri.ready;
    assign i_tri.ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    assign w_qi = (r_edge == 2'd2) ? 2'd0 : r_edge + 2'd1;
    assign w_p  = r_vtx[r_edge][r_axis];
    assign w_q  = r_vtx[w_qi][r_axis];
    assign w_d  = {w_p[COORD_W-1], w_p} - {w_q[COORD_W-1], w_q};
    assign w_m  = w_d[COORD_W] ? MAG_W'(-w_d) : w_d[MAG_W-1:0];

    assign w_f0 = (FAC_W+1)'(r_len[0]) + (FAC_W+1)'(r_len[1]) + (FAC_W+1)'(r_len[2]);
    assign w_f1 = (FAC_W+1)'(r_len[1]) + (FAC_W+1)'(r_len[2]) - (FAC_W+1)'(r_len[0]);
    assign w_f2 = (FAC_W+1)'(r_len[0]) + (FAC_W+1)'(r_len[2]) - (FAC_W+1)'(r_len[1]);
    assign w_f3 = (FAC_W+1)'(r_len[0]) + (FAC_W+1)'(r_len[1]) - (FAC_W+1)'(r_len[2]);
    assign w_degen = w_f1[FAC_W] || w_f2[FAC_W] || w_f3[FAC_W] ||
                     (w_f0 == '0) || (w_f1 == '0) || (w_f2 == '0) || (w_f3 == '0);

    assign w_psh = r_p >> SH;
    assign w_sum = {1'b0, r_total} + (SUM_W+1)'(r_area);

    assign w_mul_start = (r_state == S_SQ_GO) || (r_state == S_M1_GO) ||
                         (r_state == S_M2_GO) || (r_state == S_M3_GO);
    assign w_sq_start  = (r_state == S_RT_GO) || (r_state == S_AR_GO);

    always_comb begin
        unique case (r_state)
            S_M1_GO: begin
                w_mul_a = MUL_W'(r_f[0]);
                w_mul_b = MUL_W'(r_f[1]);
            end
            S_M2_GO: begin
                w_mul_a = MUL_W'(r_f[2]);
                w_mul_b = MUL_W'(r_f[3]);
            end
            S_M3_GO: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
            default: begin
                w_mul_a = MUL_W'(w_m);
                w_mul_b = MUL_W'(w_m);
            end
        endcase
    end

    assign w_rad = (r_state == S_AR_GO) ? w_psh[RAD_W-1:0] : RAD_W'(r_sq);

    taa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    taa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_x     (w_rad),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_acc_in) n_state = S_SQ_GO;
            S_SQ_GO:   n_state = S_SQ_WAIT;
            S_SQ_WAIT: if (w_mul_done) n_state = (r_axis == 2'd2) ? S_RT_GO : S_SQ_GO;
            S_RT_GO:   n_state = S_RT_WAIT;
            S_RT_WAIT: if (w_sq_done) n_state = (r_edge == 2'd2) ? S_FAC : S_SQ_GO;
            S_FAC:     n_state = w_degen ? S_SUM : S_M1_GO;
            S_M1_GO:   n_state = S_M1_WAIT;
            S_M1_WAIT: if (w_mul_done) n_state = S_M2_GO;
            S_M2_GO:   n_state = S_M2_WAIT;
            S_M2_WAIT: if (w_mul_done) n_state = S_M3_GO;
            S_M3_GO:   n_state = S_M3_WAIT;
            S_M3_WAIT: if (w_mul_done) n_state = S_AR_GO;
            S_AR_GO:   n_state = S_AR_WAIT;
            S_AR_WAIT: if (w_sq_done) n_state = S_SUM;
            S_SUM:     n_state = S_OUT;
            S_OUT:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
                r_total     <= r_final ? '0 : r_sum;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    r_vtx[0][0] <= i_tri.data.a_x;
                    r_vtx[0][1] <= i_tri.data.a_y;
                    r_vtx[0][2] <= i_tri.data.a_z;
                    r_vtx[1][0] <= i_tri.data.b_x;
                    r_vtx[1][1] <= i_tri.data.b_y;
                    r_vtx[1][2] <= i_tri.data.b_z;
                    r_vtx[2][0] <= i_tri.data.c_x;
                    r_vtx[2][1] <= i_tri.data.c_y;
                    r_vtx[2][2] <= i_tri.data.c_z;
                    r_final     <= i_tri.data.final_face;
                    r_edge      <= 2'd0;
                    r_axis      <= 2'd0;
                    r_sq        <= '0;
                end
            end
            S_SQ_WAIT: begin
                if (w_mul_done) begin
                    r_sq   <= r_sq + w_mul_p[SQ_W-1:0];
                    r_axis <= r_axis + 2'd1;
                end
            end
            S_RT_WAIT: begin
                if (w_sq_done) begin
                    r_len[r_edge] <= w_root[LEN_W-1:0];
                    r_sq          <= '0;
                    r_axis        <= 2'd0;
                    r_edge        <= r_edge + 2'd1;
                end
            end
            S_FAC: begin
                r_f[0] <= w_f0[FAC_W-1:0];
                r_f[1] <= w_f1[FAC_W-1:0];
                r_f[2] <= w_f2[FAC_W-1:0];
                r_f[3] <= w_f3[FAC_W-1:0];
                r_area <= '0;
            end
            S_M1_WAIT: if (w_mul_done) r_x <= w_mul_p[MUL_W-1:0];
            S_M2_WAIT: if (w_mul_done) r_y <= w_mul_p[MUL_W-1:0];
            S_M3_WAIT: if (w_mul_done) r_p <= w_mul_p;
            S_AR_WAIT: begin
                if (w_sq_done) begin
                    r_area <= (w_root[ROOT_W-1:AREA_W] != '0) ? AREA_MAX
                                                             : w_root[AREA_W-1:0];
                end
            end
            S_SUM: r_sum <= w_sum[SUM_W] ? SUM_MAX : w_sum[SUM_W-1:0];
            S_OUT: begin
                if (w_out_free) begin
                    r_res.face_area <= r_area;
                    r_res.area_sum  <= r_sum;
                    r_res.mesh_done <= r_final;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import taa_pkg::*;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1030;
    localparam int LATENCY   = 1200;
    localparam int MAX_CYC   = 30_000_000;
    localparam int LONG_HOLD = 6000;

    typedef enum int {
        PICK_SMALL,
        PICK_FULL,
        PICK_DEGEN,
        PICK_EDGE
    } t_pick;

    typedef struct {
        t_tri              tri_in;
        bit                known;
        logic [AREA_W-1:0] known_area;
    } t_row;

    typedef struct {
        t_res              res;
        bit                known;
        logic [AREA_W-1:0] known_area;
    } t_want;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    taa_tri_if tri_if ();
    taa_res_if res_if ();

    triangle_area_accumulator #(.FRAC_BITS(FRAC)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    t_want            area_queue[$];
    logic [SUM_W-1:0] mesh_total = '0;
    int               n_errors = 0;
    int               n_results = 0;
    int               cycles = 0;
    bit               feed_done = 1'b0;
    t_row             rows[$];

    function automatic logic [63:0] root128(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] edge_length(logic signed [31:0] px, logic signed [31:0] py,
                                                logic signed [31:0] pz, logic signed [31:0] qx,
                                                logic signed [31:0] qy, logic signed [31:0] qz);
        logic signed [32:0] d[3];
        logic [32:0]        m;
        logic [65:0]        acc;
        d[0] = 33'(px) - 33'(qx);
        d[1] = 33'(py) - 33'(qy);
        d[2] = 33'(pz) - 33'(qz);
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            m = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            acc += 66'(m) * 66'(m);
        end
        return root128(128'(acc));
    endfunction

    function automatic logic [AREA_W-1:0] heron(logic [63:0] la, logic [63:0] lb,
                                                logic [63:0] lc);
        logic signed [40:0] f[4];
        logic [255:0]       prod;
        logic [255:0]       scaled;
        logic [63:0]        r;
        f[0] = 41'(la) + 41'(lb) + 41'(lc);
        f[1] = 41'(lb) + 41'(lc) - 41'(la);
        f[2] = 41'(la) + 41'(lc) - 41'(lb);
        f[3] = 41'(la) + 41'(lb) - 41'(lc);
        prod = 256'd1;
        for (int i = 0; i < 4; i++) begin
            if (f[i] <= 0) begin
                return '0;
            end
            prod = prod * 256'(f[i]);
        end
        scaled = prod >> (2 * FRAC + 4);
        r = root128(scaled[127:0]);
        return (r > 64'(AREA_MAX)) ? AREA_MAX : r[AREA_W-1:0];
    endfunction

    function automatic t_res triangle_area(t_tri t);
        t_res        o;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] lc;
        logic [63:0] s;
        la = edge_length(t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z);
        lb = edge_length(t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z);
        lc = edge_length(t.c_x, t.c_y, t.c_z, t.a_x, t.a_y, t.a_z);
        o.face_area = heron(la, lb, lc);
        s = 64'(mesh_total) + 64'(o.face_area);
        o.area_sum = (s > 64'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
        o.mesh_done = t.final_face;
        return o;
    endfunction

    function automatic t_tri make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                      int x2, int y2, int z2, bit fin);
        t_tri t;
        t.a_x = x0; t.a_y = y0; t.a_z = z0;
        t.b_x = x1; t.b_y = y1; t.b_z = z1;
        t.c_x = x2; t.c_y = y2; t.c_z = z2;
        t.final_face = fin;
        return t;
    endfunction

    function automatic logic [31:0] pick_coord(t_pick p, logic [31:0] base);
        case (p)
            PICK_SMALL: return base + 32'($urandom_range(0, 20_000_000)) - 32'd10_000_000;
            PICK_EDGE:  return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                                           : 32'h8000_0000 + $urandom_range(0, 255);
            default:    return $urandom;
        endcase
    endfunction

    function automatic t_tri random_tri();
        t_tri        t;
        t_pick       p;
        logic [31:0] base;
        int          sel;
        sel = $urandom_range(0, 99);
        p = sel < 60 ? PICK_SMALL : sel < 85 ? PICK_FULL : sel < 93 ? PICK_DEGEN : PICK_EDGE;
        base = $urandom;
        if (p == PICK_DEGEN) begin
            t.a_x = $urandom; t.a_y = $urandom; t.a_z = $urandom;
            t.b_x = pick_coord(PICK_SMALL, t.a_x);
            t.b_y = pick_coord(PICK_SMALL, t.a_y);
            t.b_z = pick_coord(PICK_SMALL, t.a_z);
            if ($urandom_range(0, 1) != 0) begin
                t.c_x = t.a_x; t.c_y = t.a_y; t.c_z = t.a_z;
            end else begin
                t.c_x = t.a_x + ((t.b_x - t.a_x) >>> 1);
                t.c_y = t.a_y + ((t.b_y - t.a_y) >>> 1);
                t.c_z = t.a_z + ((t.b_z - t.a_z) >>> 1);
            end
        end else begin
            t.a_x = pick_coord(p, base); t.a_y = pick_coord(p, base);
            t.a_z = pick_coord(p, base); t.b_x = pick_coord(p, base);
            t.b_y = pick_coord(p, base); t.b_z = pick_coord(p, base);
            t.c_x = pick_coord(p, base); t.c_y = pick_coord(p, base);
            t.c_z = pick_coord(p, base);
        end
        t.final_face = ($urandom_range(0, 19) == 0);
        return t;
    endfunction

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 0;
        if (sel < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 1500);
    endfunction

    // Each monitored transaction is predicted at the edge where it is accepted.
    always @(posedge i_clk) begin
        t_want w;
        t_res  got;
        cycles <= cycles + 1;
        if (i_rst_n && tri_if.valid && tri_if.ready) begin
            w.res = triangle_area(tri_if.data);
            w.known = 1'b0;
            w.known_area = '0;
            if (rows.size() > 0) begin
                w.known = rows[0].known;
                w.known_area = rows[0].known_area;
                rows.pop_front();
            end
            mesh_total = w.res.mesh_done ? '0 : w.res.area_sum;
            area_queue.push_back(w);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            n_results <= n_results + 1;
            if (area_queue.size() == 0) begin
                $error("result with nothing expected: face_area %0d", got.face_area);
                n_errors++;
            end else begin
                w = area_queue.pop_front();
                if (got.face_area !== w.res.face_area) begin
                    $error("face_area expected %0d actual %0d", w.res.face_area, got.face_area);
                    n_errors++;
                end
                if (w.known && got.face_area !== w.known_area) begin
                    $error("face_area expected %0d actual %0d", w.known_area, got.face_area);
                    n_errors++;
                end
                if (got.area_sum !== w.res.area_sum) begin
                    $error("area_sum expected %0d actual %0d", w.res.area_sum, got.area_sum);
                    n_errors++;
                end
                if (got.mesh_done !== w.res.mesh_done) begin
                    $error("mesh_done expected %0d actual %0d", w.res.mesh_done, got.mesh_done);
                    n_errors++;
                end
            end
        end
    end

    // Result side: random backpressure, one long hold that stalls the accumulator.
    initial begin
        int  hold;
        bit  held;
        held = 1'b0;
        res_if.ready = 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (!held && n_results >= 150) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            hold = gap_len();
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_tri(t_tri t);
        int gap;
        tri_if.valid <= 1'b1;
        tri_if.data <= t;
        do @(posedge i_clk); while (!tri_if.ready);
        gap = gap_len();
        if (gap > 0) begin
            tri_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_row table_rows[$];
        t_row r;
        tri_if.valid = 1'b0;
        tri_if.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        r.known = 1'b1; r.known_area = '0;
        r.tri_in = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        table_rows.push_back(r);
        r.tri_in = make_tri(65536, 65536, 0, 131072, 131072, 0, 196608, 196608, 0, 0);
        table_rows.push_back(r);
        r.tri_in = make_tri(-5, 7, 9, -5, 7, 9, 1000, 1000, 1000, 0);
        table_rows.push_back(r);
        r.known = 1'b0;
        r.tri_in = make_tri(32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0);
        table_rows.push_back(r);
        table_rows.push_back(r);
        r.tri_in.final_face = 1'b1;
        table_rows.push_back(r);
        r.known = 1'b0;
        r.tri_in = make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0);
        table_rows.push_back(r);
        r.tri_in = make_tri(32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 0,
                            32'h80000000, 32'h7FFFFFFF, 0, 0);
        table_rows.push_back(r);
        r.tri_in = make_tri(-1, -1, -1, 1, 0, 0, 0, 1, 0, 0);
        table_rows.push_back(r);
        r.tri_in = make_tri(0, 0, 0, 300000, 0, 0, 150000, 259808, 0, 1);
        table_rows.push_back(r);
        r.tri_in = make_tri(0, 0, 0, 32'h7FFFFFFF, 0, 0, 1, 1, 0, 0);
        table_rows.push_back(r);
        r.tri_in = make_tri(0, 0, 1, 0, 1, 0, 1, 0, 0, 1);
        table_rows.push_back(r);

        foreach (table_rows[i]) begin
            rows.push_back(table_rows[i]);
            send_tri(table_rows[i].tri_in);
        end
        repeat (N_RANDOM) send_tri(random_tri());
        tri_if.valid <= 1'b0;
        feed_done = 1'b1;
    end

    initial begin
        wait (feed_done);
        while (area_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (n_errors == 0 && area_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles >= MAX_CYC) begin
            $display("TB_ERROR");
            $finish;
        end
    end
endmodule
